// ----- rtl/core/fm_phase_discriminator_assert.svh -----
// Assertion macros for the FM phase discriminator.
// Included by the top level; no other dependencies.
`ifndef FM_PHASE_DISCRIMINATOR_ASSERT_SVH
`define FM_PHASE_DISCRIMINATOR_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define FMD_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define FMD_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define FMD_ASSERT(lbl, clk, rst_n, prop, msg)
`define FMD_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

// ----- rtl/core/fmd_pkg.sv -----
// Shared types, constants, microcode and arctangent table of the FM phase discriminator.
// No dependencies.
package fmd_pkg;

  localparam int unsigned SAMPLE_W_DEF     = 16;
  localparam int unsigned CORDIC_STEPS_DEF = 14;
  localparam int unsigned SCALE_SH         = 16;
  localparam int unsigned ATAN_DEPTH       = 24;
  localparam int unsigned ATAN_IDX_W       = 5;
  localparam int unsigned ATAN_W           = 32;
  localparam int unsigned ANG_W            = 34;
  localparam int unsigned ANG_FRAC_SH      = 18;
  localparam int unsigned PHASE_W          = 15;
  localparam int unsigned DIFF_W           = 16;
  localparam int unsigned DEEMPH_W         = 16;
  localparam int unsigned ACC_W            = 32;
  localparam int unsigned ACC_FRAC_SH      = 15;
  localparam int unsigned AUDIO_W          = 15;
  localparam int unsigned PC_W             = 3;

  localparam logic [DEEMPH_W-1:0] DEEMPH_ONE = 16'd32768;
  localparam logic [DEEMPH_W-1:0] DEEMPH_RST = 16'd8192;
  localparam logic signed [PHASE_W-1:0] PHASE_PI      = 15'sd8192;
  localparam logic signed [PHASE_W-1:0] PHASE_HALF_PI = 15'sd4096;
  localparam logic signed [DIFF_W:0]    PHASE_TWO_PI  = 17'sd16384;
  localparam logic signed [ANG_W-1:0]   ANG_HALF_PI   = 34'sd1073741824;

  typedef enum logic [2:0] {
    OP_WAIT,
    OP_ITER,
    OP_ROUND,
    OP_DIFF,
    OP_MUL,
    OP_ACC,
    OP_OUT
  } fmd_op_e;

  typedef enum logic [1:0] {
    COND_NEXT,
    COND_IN,
    COND_LOOP,
    COND_OUT
  } fmd_cond_e;

  typedef struct packed {
    fmd_op_e             op;
    fmd_cond_e           cond;
    logic [PC_W-1:0]     target;
  } fmd_uword_t;

  typedef struct packed {
    fmd_op_e op;
    logic    fire;
  } fmd_ctl_t;

  typedef struct packed {
    logic in_valid;
    logic out_free;
  } fmd_stat_t;

  function automatic fmd_uword_t ucode(logic [PC_W-1:0] pc);
    fmd_uword_t w;
    unique case (pc)
      3'd0:    w = '{op: OP_WAIT,  cond: COND_IN,   target: 3'd0};
      3'd1:    w = '{op: OP_ITER,  cond: COND_LOOP, target: 3'd1};
      3'd2:    w = '{op: OP_ROUND, cond: COND_NEXT, target: 3'd0};
      3'd3:    w = '{op: OP_DIFF,  cond: COND_NEXT, target: 3'd0};
      3'd4:    w = '{op: OP_MUL,   cond: COND_NEXT, target: 3'd0};
      3'd5:    w = '{op: OP_ACC,   cond: COND_NEXT, target: 3'd0};
      3'd6:    w = '{op: OP_OUT,   cond: COND_OUT,  target: 3'd0};
      default: w = '{op: OP_WAIT,  cond: COND_OUT,  target: 3'd0};
    endcase
    return w;
  endfunction

  // atan(2^-k), pi = 2^31
  function automatic logic [ATAN_W-1:0] atan_ang(logic [ATAN_IDX_W-1:0] idx);
    logic [ATAN_W-1:0] a;
    unique case (idx)
      5'd0:    a = 32'h20000000;
      5'd1:    a = 32'h12E4051E;
      5'd2:    a = 32'h09FB385B;
      5'd3:    a = 32'h051111D4;
      5'd4:    a = 32'h028B0D43;
      5'd5:    a = 32'h0145D7E1;
      5'd6:    a = 32'h00A2F61E;
      5'd7:    a = 32'h00517C55;
      5'd8:    a = 32'h0028BE53;
      5'd9:    a = 32'h00145F2F;
      5'd10:   a = 32'h000A2F98;
      5'd11:   a = 32'h000517CC;
      5'd12:   a = 32'h00028BE6;
      5'd13:   a = 32'h000145F3;
      5'd14:   a = 32'h0000A2FA;
      5'd15:   a = 32'h0000517D;
      5'd16:   a = 32'h000028BE;
      5'd17:   a = 32'h0000145F;
      5'd18:   a = 32'h00000A30;
      5'd19:   a = 32'h00000518;
      5'd20:   a = 32'h0000028C;
      5'd21:   a = 32'h00000146;
      5'd22:   a = 32'h000000A3;
      5'd23:   a = 32'h00000051;
      default: a = '0;
    endcase
    return a;
  endfunction

endpackage

// ----- rtl/core/fmd_if.sv -----
// Stream interfaces of the FM phase discriminator: I/Q input beats and audio output beats.
// Depends on fmd_pkg.
interface fmd_iq_if
  import fmd_pkg::*;
#(
  parameter int unsigned SAMPLE_WIDTH = SAMPLE_W_DEF
) ();
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] i_sample;
  logic signed [SAMPLE_WIDTH-1:0] q_sample;

  modport source (output valid, output i_sample, output q_sample, input ready);
  modport sink   (input valid, input i_sample, input q_sample, output ready);
endinterface

interface fmd_audio_if
  import fmd_pkg::*;
();
  logic                      valid;
  logic                      ready;
  logic signed [AUDIO_W-1:0] audio_out;

  modport source (output valid, output audio_out, input ready);
  modport sink   (input valid, input audio_out, output ready);
endinterface

// ----- rtl/core/fmd_seq.sv -----
// Microcode sequencer: program counter, CORDIC step counter and control word decode.
// Depends on fmd_pkg.
module fmd_seq
  import fmd_pkg::*;
#(
  parameter int unsigned CORDIC_STEPS = CORDIC_STEPS_DEF,
  localparam int unsigned STEPS = (CORDIC_STEPS > ATAN_DEPTH) ? ATAN_DEPTH : CORDIC_STEPS,
  localparam int unsigned CNT_W = $clog2(STEPS)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  fmd_stat_t        stat_i,
  output fmd_ctl_t         ctl_o,
  output logic [CNT_W-1:0] cnt_o
);

  localparam logic [CNT_W-1:0] LAST = CNT_W'(STEPS - 1);

  logic [PC_W-1:0]  pc_q, pc_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  fmd_uword_t       uw;
  logic             fire;
  logic             last;

  assign uw   = ucode(pc_q);
  assign last = (cnt_q == LAST);

  always_comb begin
    fire = 1'b1;
    pc_d = pc_q + PC_W'(1);
    unique case (uw.cond)
      COND_NEXT: ;
      COND_IN: begin
        fire = stat_i.in_valid;
        pc_d = fire ? pc_q + PC_W'(1) : pc_q;
      end
      COND_LOOP: begin
        pc_d = last ? pc_q + PC_W'(1) : uw.target;
      end
      COND_OUT: begin
        fire = stat_i.out_free;
        pc_d = fire ? uw.target : pc_q;
      end
      default: ;
    endcase
    cnt_d = cnt_q;
    if (uw.op == OP_ITER) begin
      cnt_d = last ? '0 : cnt_q + CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q  <= '0;
      cnt_q <= '0;
    end else begin
      pc_q  <= pc_d;
      cnt_q <= cnt_d;
    end
  end

  assign ctl_o = '{op: uw.op, fire: fire};
  assign cnt_o = cnt_q;

endmodule

// ----- rtl/core/fm_phase_discriminator.sv -----
// FM phase discriminator top level: CORDIC phase, wrap-corrected difference, de-emphasis.
// Depends on fmd_pkg, fmd_if, fmd_seq and fm_phase_discriminator_assert.svh.
//
// Usage:
//   iq_i carries one I/Q pair per beat (valid/ready). audio_o carries one audio sample
//   per beat. deemph_we_i/deemph_wdata_i write the de-emphasis weight K (Q1.15); write
//   it only while no sample is in flight.
//   A beat on iq_i is taken only while the sequencer waits at its first step. After
//   that the microcode runs CORDIC_STEPS vectoring steps (capped at ATAN_DEPTH) of the
//   shared shift-add unit, then round, difference, multiply and accumulate steps, and
//   loads the output register; only then does it return to its first step, so a new
//   sample is not taken while the last one is still being computed.
//   If the receiver stalls, the result holds in the output register; the next sample is
//   still accepted and computed, and its load waits until the register is free.
//   Reset clears the sequencer, previous phase, filter state and output valid, and sets
//   K to 8192.
`include "fm_phase_discriminator_assert.svh"
module fm_phase_discriminator
  import fmd_pkg::*;
#(
  parameter int unsigned SAMPLE_WIDTH = SAMPLE_W_DEF,
  parameter int unsigned CORDIC_STEPS = CORDIC_STEPS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  fmd_iq_if.sink              iq_i,
  fmd_audio_if.source         audio_o,
  input  logic                deemph_we_i,
  input  logic [DEEMPH_W-1:0] deemph_wdata_i
);

  localparam int unsigned STEPS = (CORDIC_STEPS > ATAN_DEPTH) ? ATAN_DEPTH : CORDIC_STEPS;
  localparam int unsigned CNT_W = $clog2(STEPS);
  localparam int unsigned EXT_W = 2;
  localparam int unsigned W     = SAMPLE_WIDTH + SCALE_SH + EXT_W;
  localparam int unsigned PA_W  = DEEMPH_W + 1 + DIFF_W;
  localparam int unsigned PB_W  = DEEMPH_W + 1 + ACC_W;

  fmd_ctl_t         ctl;
  fmd_stat_t        stat;
  logic [CNT_W-1:0] cnt;

  logic signed [W-1:0]       x_q, y_q;
  logic signed [ANG_W-1:0]   z_q;
  logic                      zero_q;
  logic signed [PHASE_W-1:0] cur_q, prev_q;
  logic signed [DIFF_W-1:0]  diff_q;
  logic signed [PA_W-1:0]    pa_q;
  logic signed [PB_W-1:0]    pb_q;
  logic signed [ACC_W-1:0]   acc_q;
  logic [DEEMPH_W-1:0]       coeff_q;
  logic                      out_valid_q;
  logic signed [AUDIO_W-1:0] out_q;

  logic signed [W-1:0]       xi, yi, x0, y0, dx, dy;
  logic signed [ANG_W-1:0]   z0, ang, zsum;
  logic signed [DIFF_W:0]    zr;
  logic signed [PHASE_W-1:0] cur_d;
  logic signed [DIFF_W:0]    draw, dfix;
  logic [DEEMPH_W-1:0]       k, kc;
  logic signed [PB_W-1:0]    pb_rnd;
  logic signed [ACC_W-1:0]   acc_d, acc_rnd;

  fmd_seq #(
    .CORDIC_STEPS(CORDIC_STEPS)
  ) u_seq (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .stat_i(stat),
    .ctl_o (ctl),
    .cnt_o (cnt)
  );

  assign iq_i.ready = (ctl.op == OP_WAIT);
  assign stat       = '{in_valid: iq_i.valid, out_free: !out_valid_q || audio_o.ready};

  // Scale and turn left-half-plane vectors into the right half plane
  always_comb begin
    xi = {{EXT_W{iq_i.i_sample[SAMPLE_WIDTH-1]}}, iq_i.i_sample, SCALE_SH'(0)};
    yi = {{EXT_W{iq_i.q_sample[SAMPLE_WIDTH-1]}}, iq_i.q_sample, SCALE_SH'(0)};
    x0 = xi;
    y0 = yi;
    z0 = '0;
    if (xi[W-1]) begin
      if (!yi[W-1]) begin
        x0 = yi;
        y0 = -xi;
        z0 = ANG_HALF_PI;
      end else begin
        x0 = -yi;
        y0 = xi;
        z0 = -ANG_HALF_PI;
      end
    end
  end

  assign dx  = y_q >>> cnt;
  assign dy  = x_q >>> cnt;
  assign ang = $signed({{(ANG_W - ATAN_W){1'b0}}, atan_ang(ATAN_IDX_W'(cnt))});

  // Round to pi = 8192 and clamp
  always_comb begin
    zsum = z_q + ANG_W'(1 << (ANG_FRAC_SH - 1));
    zr   = $signed(zsum[ANG_W-1:ANG_FRAC_SH-1]) >>> 1;
    if (zero_q) begin
      cur_d = '0;
    end else if (zr > $signed({{(DIFF_W + 1 - PHASE_W){1'b0}}, PHASE_PI})) begin
      cur_d = PHASE_PI;
    end else if (zr < -$signed({{(DIFF_W + 1 - PHASE_W){1'b0}}, PHASE_PI})) begin
      cur_d = -PHASE_PI;
    end else begin
      cur_d = PHASE_W'(zr);
    end
  end

  always_comb begin
    draw = (DIFF_W + 1)'(cur_q) - (DIFF_W + 1)'(prev_q);
    priority if (cur_q > PHASE_HALF_PI && prev_q < -PHASE_HALF_PI) begin
      dfix = draw - PHASE_TWO_PI;
    end else if (cur_q < -PHASE_HALF_PI && prev_q > PHASE_HALF_PI) begin
      dfix = draw + PHASE_TWO_PI;
    end else begin
      dfix = draw;
    end
  end

  assign k       = (coeff_q > DEEMPH_ONE) ? DEEMPH_ONE : coeff_q;
  assign kc      = DEEMPH_ONE - k;
  assign pb_rnd  = (pb_q + PB_W'(1 << (ACC_FRAC_SH - 1))) >>> ACC_FRAC_SH;
  assign acc_d   = ACC_W'(pa_q) + ACC_W'(pb_rnd);
  assign acc_rnd = acc_q + ACC_W'(1 << (ACC_FRAC_SH - 1));

  always_ff @(posedge clk_i) begin
    unique case (ctl.op)
      OP_WAIT: begin
        if (ctl.fire) begin
          x_q    <= x0;
          y_q    <= y0;
          z_q    <= z0;
          zero_q <= (iq_i.i_sample == '0) && (iq_i.q_sample == '0);
        end
      end
      OP_ITER: begin
        if (!y_q[W-1]) begin
          x_q <= x_q + dx;
          y_q <= y_q - dy;
          z_q <= z_q + ang;
        end else begin
          x_q <= x_q - dx;
          y_q <= y_q + dy;
          z_q <= z_q - ang;
        end
      end
      OP_ROUND: cur_q  <= cur_d;
      OP_DIFF:  diff_q <= DIFF_W'(dfix);
      OP_MUL: begin
        pa_q <= PA_W'($signed({1'b0, k}) * diff_q);
        pb_q <= PB_W'($signed({1'b0, kc}) * acc_q);
      end
      OP_OUT: begin
        if (ctl.fire) begin
          out_q <= acc_rnd[ACC_FRAC_SH+AUDIO_W-1:ACC_FRAC_SH];
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q      <= '0;
      acc_q       <= '0;
      coeff_q     <= DEEMPH_RST;
      out_valid_q <= 1'b0;
    end else begin
      if (deemph_we_i) begin
        coeff_q <= deemph_wdata_i;
      end
      if (ctl.op == OP_DIFF) begin
        prev_q <= cur_q;
      end
      if (ctl.op == OP_ACC) begin
        acc_q <= acc_d;
      end
      if (ctl.op == OP_OUT && ctl.fire) begin
        out_valid_q <= 1'b1;
      end else if (audio_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign audio_o.valid     = out_valid_q;
  assign audio_o.audio_out = out_q;

  `FMD_ASSERT(a_one_beat_per_sample, clk_i, rst_ni, iq_i.valid && iq_i.ready |=> !iq_i.ready, "input accepted twice in a row")
  `FMD_ASSERT(a_load_from_out_step, clk_i, rst_ni, $rose(audio_o.valid) |-> $past(ctl.op == OP_OUT), "output loaded outside output step")
  `FMD_ASSERT(a_zero_vector_phase, clk_i, rst_ni, (ctl.op == OP_ROUND) && zero_q |=> cur_q == '0, "zero vector gave nonzero phase")
  `FMD_ASSERT_ALWAYS(a_reset_no_output, clk_i, !rst_ni |=> !audio_o.valid, "output valid during reset")

endmodule
